### rtl/dam_pkg.sv
// Shared types, constants and decode helpers for the decimal accumulator machine.
package dam_pkg;

  localparam int MEM_WORDS_DEF = 1000;
  localparam int WORD_W        = 18;
  localparam int ADDR_W        = 10;
  localparam int STAT_W        = 4;
  localparam int OPC_W         = 8;
  localparam int VAL_LIMIT     = 99999;
  localparam int DEC_BASE      = 1000;

  localparam logic [OPC_W-1:0] OP_READ  = 8'd10;
  localparam logic [OPC_W-1:0] OP_WRITE = 8'd11;
  localparam logic [OPC_W-1:0] OP_NL    = 8'd12;
  localparam logic [OPC_W-1:0] OP_LOAD  = 8'd20;
  localparam logic [OPC_W-1:0] OP_ADD   = 8'd30;
  localparam logic [OPC_W-1:0] OP_SUB   = 8'd31;
  localparam logic [OPC_W-1:0] OP_DIV   = 8'd32;
  localparam logic [OPC_W-1:0] OP_MUL   = 8'd33;
  localparam logic [OPC_W-1:0] OP_MOD   = 8'd34;
  localparam logic [OPC_W-1:0] OP_POW   = 8'd35;
  localparam logic [OPC_W-1:0] OP_BR    = 8'd40;
  localparam logic [OPC_W-1:0] OP_BRN   = 8'd41;
  localparam logic [OPC_W-1:0] OP_BRZ   = 8'd42;
  localparam logic [OPC_W-1:0] OP_HALT  = 8'd99;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED  = 4'd0,
    ST_EXEC    = 4'd1,
    ST_OUT     = 4'd2,
    ST_NL      = 4'd3,
    ST_HALT    = 4'd4,
    ST_OVF     = 4'd5,
    ST_DIV0    = 4'd6,
    ST_BADOP   = 4'd7,
    ST_BADCODE = 4'd8,
    ST_IDLE    = 4'd9
  } stat_t;

  typedef enum logic [1:0] {
    RUN_GO     = 2'd0,
    RUN_HALTED = 2'd1,
    RUN_FAULT  = 2'd2
  } run_t;

  typedef enum logic [3:0] {
    K_READ, K_WRITE, K_NL, K_LOAD, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
    K_POW, K_BR, K_BRN, K_BRZ, K_HALT, K_BAD
  } kind_t;

  typedef struct packed {
    logic in_rdy;
    logic clr_we;
    logic disp;
    logic fetch_rd;
    logic dec_start;
    logic dec_cap;
    logic opd_rd;
    logic m_cap;
    logic exec;
    logic mul_en;
    logic mul_chk;
    logic ar_cap;
    logic pchk;
    logic commit;
  } dam_cmd_t;

  typedef struct packed {
    logic  in_acc;
    logic  clr_done;
    logic  act;
    logic  run_go;
    logic  pc_bad;
    logic  div_done;
    logic  dec_fault;
    logic  mem_op;
    kind_t kind;
    logic  m_zero;
    logic  pow_iter;
    logic  pow_stop;
    logic  out_free;
  } dam_stat_t;

  function automatic kind_t kind_of(input logic [OPC_W-1:0] opc);
    kind_t k;
    unique case (opc)
      OP_READ:  k = K_READ;
      OP_WRITE: k = K_WRITE;
      OP_NL:    k = K_NL;
      OP_LOAD:  k = K_LOAD;
      OP_ADD:   k = K_ADD;
      OP_SUB:   k = K_SUB;
      OP_DIV:   k = K_DIV;
      OP_MUL:   k = K_MUL;
      OP_MOD:   k = K_MOD;
      OP_POW:   k = K_POW;
      OP_BR:    k = K_BR;
      OP_BRN:   k = K_BRN;
      OP_BRZ:   k = K_BRZ;
      OP_HALT:  k = K_HALT;
      default:  k = K_BAD;
    endcase
    return k;
  endfunction

endpackage

### rtl/dam_ifs.sv
// Item channel interfaces: step/load requests in, step results out.
interface dam_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [dam_pkg::ADDR_W-1:0]   address;
  logic signed [dam_pkg::WORD_W-1:0]   word;
  modport source (output valid, action, address, word, input ready);
  modport sink   (input valid, action, address, word, output ready);
endinterface

interface dam_out_if;
  logic                                valid;
  logic                                ready;
  logic        [dam_pkg::STAT_W-1:0]   status;
  logic signed [dam_pkg::WORD_W-1:0]   out_value;
  logic        [dam_pkg::ADDR_W-1:0]   counter;
  logic signed [dam_pkg::WORD_W-1:0]   accum_value;
  modport source (output valid, status, out_value, counter, accum_value, input ready);
  modport sink   (input valid, status, out_value, counter, accum_value, output ready);
endinterface

### rtl/dam_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dam_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dam_pkg::WORD_W-1:0]  num,
  input  logic [dam_pkg::WORD_W-1:0]  den,
  output logic                        done,
  output logic [dam_pkg::WORD_W-1:0]  quo,
  output logic [dam_pkg::WORD_W-1:0]  rem
);
  import dam_pkg::*;

  localparam int CW = $clog2(WORD_W + 1);

  logic [CW-1:0]     cnt;
  logic              busy;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   sh;
  logic [WORD_W:0]   diff;
  logic              take;

  assign sh   = {rem, quo[WORD_W-1]};
  assign diff = sh - {1'b0, dvs};
  assign take = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= take ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], take};
    end
  end

endmodule

### rtl/dam_dp.sv
// Datapath: word memory, machine registers, arithmetic units and result register.
module dam_dp #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  dam_in_if.sink             item_in,
  dam_out_if.source          result_out,
  input  dam_pkg::dam_cmd_t  cmd,
  output dam_pkg::dam_stat_t st
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [ADDR_W-1:0] MEM_TOP = ADDR_W'(MEM_WORDS);
  localparam logic signed [35:0] LIM = 36'(VAL_LIMIT);
  // x / 1000 = (x * ceil(2^28 / 1000)) >> 28, exact for any 18-bit x
  localparam int DEC_SH = 28;
  localparam logic [WORD_W:0] DEC_RCP = 19'd268436;

  function automatic logic fits(input logic signed [35:0] v);
    return (v <= LIM) && (v >= -LIM);
  endfunction

  // captured item
  logic                     act;
  logic [ADDR_W-1:0]        addr;
  logic signed [WORD_W-1:0] wd;
  // machine state
  logic signed [WORD_W-1:0] accum;
  logic [ADDR_W-1:0]        pc;
  run_t                     run;
  // memory
  logic signed [WORD_W-1:0] mem [MEM_WORDS];
  logic signed [WORD_W-1:0] mem_q;
  logic [AW-1:0]            clr_addr;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_wa, mem_ra;
  logic signed [WORD_W-1:0] mem_wd;
  // decoded instruction and operands
  logic                     ir_neg;
  logic [OPC_W-1:0]         opc;
  logic [ADDR_W-1:0]        opd;
  logic signed [WORD_W-1:0] m;
  kind_t                    kind;
  logic                     mem_op;
  logic [OPC_W-1:0]         dq;
  logic [2*WORD_W:0]        dec_prod;
  logic [WORD_W-1:0]        dec_rem;
  // arithmetic
  logic signed [WORD_W-1:0] res, pr, mul_a;
  logic                     ovf, div0;
  logic [WORD_W-2:0]        pcnt;
  logic signed [35:0]       prod;
  logic signed [WORD_W:0]   sum, qs, rs, ar;
  logic [WORD_W-1:0]        a_abs, m_abs, ir_abs;
  logic signed [WORD_W-1:0] pow_res, par_one;
  logic                     pow_ovf;
  // divider
  logic                     div_start, div_done;
  logic [WORD_W-1:0]        div_num, div_den, div_q, div_r;
  // commit
  stat_t                    stat_c;
  logic [ADDR_W-1:0]        pc_n;
  logic signed [WORD_W-1:0] acc_n;
  run_t                     run_n;
  logic                     load_wr, read_wr;

  assign kind = ir_neg ? K_BAD : kind_of(opc);

  always_comb begin
    case (kind) inside
      K_READ, K_WRITE, K_LOAD, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_POW: mem_op = 1'b1;
      default: mem_op = 1'b0;
    endcase
  end

  assign a_abs  = accum[WORD_W-1] ? WORD_W'(-accum) : WORD_W'(accum);
  assign m_abs  = m[WORD_W-1] ? WORD_W'(-m) : WORD_W'(m);
  assign ir_abs = mem_q[WORD_W-1] ? WORD_W'(-mem_q) : WORD_W'(mem_q);

  // decode: quotient by reciprocal multiply, remainder on the next cycle
  assign dec_prod = (2*WORD_W+1)'(ir_abs) * (2*WORD_W+1)'(DEC_RCP);
  assign dec_rem  = ir_abs - WORD_W'(dq) * WORD_W'(DEC_BASE);

  assign div_start = cmd.exec & ((kind == K_DIV) | (kind == K_MOD)) & (m != '0);
  assign div_num   = a_abs;
  assign div_den   = m_abs;

  dam_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // truncating signed quotient and remainder
  always_comb begin
    qs = (accum[WORD_W-1] ^ m[WORD_W-1]) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    rs = accum[WORD_W-1] ? -$signed({1'b0, div_r}) : $signed({1'b0, div_r});
    ar = (kind == K_DIV) ? qs : rs;
    sum = (kind == K_SUB) ? ((WORD_W+1)'(accum) - (WORD_W+1)'(m))
                          : ((WORD_W+1)'(accum) + (WORD_W+1)'(m));
  end

  // power with a trivial base or a non-positive exponent
  always_comb begin
    par_one = m[0] ? -WORD_W'(1) : WORD_W'(1);
    pow_ovf = 1'b0;
    if (m[WORD_W-1]) begin
      pow_ovf = (accum == '0);
      if (accum == WORD_W'(1))       pow_res = WORD_W'(1);
      else if (accum == -WORD_W'(1)) pow_res = par_one;
      else                           pow_res = '0;
    end else if (m == '0) begin
      pow_res = WORD_W'(1);
    end else if (accum == -WORD_W'(1)) begin
      pow_res = par_one;
    end else begin
      pow_res = accum;
    end
  end

  assign mul_a = (kind == K_POW) ? pr : m;

  always_ff @(posedge clk) begin
    if (st.in_acc) begin
      act  <= item_in.action;
      addr <= item_in.address;
      wd   <= item_in.word;
    end
    if (cmd.disp) begin
      ovf  <= 1'b0;
      div0 <= 1'b0;
    end
    if (cmd.dec_start) begin
      ir_neg <= mem_q[WORD_W-1];
      dq     <= dec_prod[DEC_SH +: OPC_W];
    end
    if (cmd.dec_cap) begin
      opc <= dq;
      opd <= dec_rem[ADDR_W-1:0];
    end
    if (cmd.m_cap) m <= mem_q;
    if (cmd.exec) begin
      case (kind)
        K_ADD, K_SUB: begin
          res <= sum[WORD_W-1:0];
          ovf <= !fits(36'(sum));
        end
        K_DIV, K_MOD: if (m == '0) div0 <= 1'b1;
        K_POW: begin
          if (st.pow_iter) begin
            pr   <= WORD_W'(1);
            pcnt <= m[WORD_W-2:0];
          end else begin
            res <= pow_res;
            ovf <= pow_ovf;
          end
        end
        default: ;
      endcase
    end
    if (cmd.mul_en) prod <= mul_a * accum;
    if (cmd.mul_chk) begin
      res <= prod[WORD_W-1:0];
      ovf <= !fits(prod);
    end
    if (cmd.ar_cap) begin
      res <= ar[WORD_W-1:0];
      ovf <= !fits(36'(ar));
    end
    if (cmd.pchk) begin
      if (!fits(prod)) begin
        ovf <= 1'b1;
      end else begin
        pr   <= prod[WORD_W-1:0];
        res  <= prod[WORD_W-1:0];
        pcnt <= pcnt - 1'b1;
      end
    end
  end

  // final status of the item
  always_comb begin
    if (!act)                               stat_c = ST_LOADED;
    else if (run != RUN_GO)                 stat_c = ST_IDLE;
    else if (pc >= MEM_TOP)                 stat_c = ST_BADOP;
    else if (ir_neg && opd != '0)           stat_c = ST_BADOP;
    else if (kind == K_BAD)                 stat_c = ST_BADCODE;
    else if (st.dec_fault)                  stat_c = ST_BADOP;
    else if (div0)                          stat_c = ST_DIV0;
    else if (ovf)                           stat_c = ST_OVF;
    else if (kind == K_HALT)                stat_c = ST_HALT;
    else if (kind == K_WRITE)               stat_c = ST_OUT;
    else if (kind == K_NL)                  stat_c = ST_NL;
    else                                    stat_c = ST_EXEC;
  end

  always_comb begin
    pc_n  = pc;
    acc_n = accum;
    run_n = run;
    case (stat_c) inside
      ST_EXEC, ST_OUT, ST_NL: begin
        if ((kind == K_BR) || (kind == K_BRN && accum[WORD_W-1]) ||
            (kind == K_BRZ && accum == '0))
          pc_n = opd;
        else
          pc_n = pc + 1'b1;
        case (kind) inside
          K_LOAD: acc_n = m;
          K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_POW: acc_n = res;
          default: ;
        endcase
      end
      ST_HALT: run_n = RUN_HALTED;
      ST_OVF, ST_DIV0, ST_BADOP, ST_BADCODE: run_n = RUN_FAULT;
      default: ;
    endcase
  end

  assign load_wr = (stat_c == ST_LOADED) && (addr < MEM_TOP);
  assign read_wr = (stat_c == ST_EXEC) && (kind == K_READ);
  assign mem_we  = cmd.clr_we | (cmd.commit & (load_wr | read_wr));
  assign mem_wa  = cmd.clr_we ? clr_addr : (load_wr ? addr[AW-1:0] : opd[AW-1:0]);
  assign mem_wd  = cmd.clr_we ? '0 : wd;
  assign mem_re  = cmd.fetch_rd | cmd.opd_rd;
  assign mem_ra  = cmd.fetch_rd ? pc[AW-1:0] : opd[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum            <= '0;
      pc               <= '0;
      run              <= RUN_GO;
      clr_addr         <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (cmd.clr_we) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        accum            <= acc_n;
        pc               <= pc_n;
        run              <= run_n;
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_out.status      <= stat_c;
      result_out.out_value   <= (stat_c == ST_OUT) ? m : '0;
      result_out.counter     <= pc_n;
      result_out.accum_value <= acc_n;
    end
  end

  assign item_in.ready = cmd.in_rdy;

  always_comb begin
    st.in_acc    = item_in.valid & cmd.in_rdy;
    st.clr_done  = (clr_addr == AW'(MEM_WORDS - 1));
    st.act       = act;
    st.run_go    = (run == RUN_GO);
    st.pc_bad    = (pc >= MEM_TOP);
    st.div_done  = div_done;
    st.dec_fault = (ir_neg && opd != '0) || (mem_op && opd >= MEM_TOP) || (kind == K_BAD);
    st.mem_op    = mem_op;
    st.kind      = kind;
    st.m_zero    = (m == '0);
    st.pow_iter  = !m[WORD_W-1] && (m != '0) && (accum != '0) &&
                   (accum != WORD_W'(1)) && (accum != -WORD_W'(1));
    st.pow_stop  = !fits(prod) || (pcnt == (WORD_W-1)'(1));
    st.out_free  = !result_out.valid | result_out.ready;
  end

endmodule

### rtl/dam_ctrl.sv
// Controller: sequences clear, fetch, decode, operand read, execute and commit.
module dam_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  dam_pkg::dam_stat_t st,
  output dam_pkg::dam_cmd_t  cmd
);
  import dam_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_DISP  = 15'h0004,
    S_FETCH = 15'h0008,
    S_IRCAP = 15'h0010,
    S_DECW  = 15'h0020,
    S_CHK   = 15'h0040,
    S_OPRD  = 15'h0080,
    S_MCAP  = 15'h0100,
    S_EXEC  = 15'h0200,
    S_MULW  = 15'h0400,
    S_ARW   = 15'h0800,
    S_PMUL  = 15'h1000,
    S_PCHK  = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (st.in_acc) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        if (!st.act || !st.run_go || st.pc_bad) state_next = S_FIN;
        else                                    state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch_rd = 1'b1;
        state_next   = S_IRCAP;
      end
      S_IRCAP: begin
        cmd.dec_start = 1'b1;
        state_next    = S_DECW;
      end
      S_DECW: begin
        cmd.dec_cap = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (st.dec_fault || !st.mem_op) state_next = S_FIN;
        else                            state_next = S_OPRD;
      end
      S_OPRD: begin
        cmd.opd_rd = 1'b1;
        state_next = S_MCAP;
      end
      S_MCAP: begin
        cmd.m_cap  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.kind) inside
          K_MUL: begin
            cmd.mul_en = 1'b1;
            state_next = S_MULW;
          end
          K_DIV, K_MOD: state_next = st.m_zero ? S_FIN : S_ARW;
          K_POW:        state_next = st.pow_iter ? S_PMUL : S_FIN;
          default:      state_next = S_FIN;
        endcase
      end
      S_MULW: begin
        cmd.mul_chk = 1'b1;
        state_next  = S_FIN;
      end
      S_ARW: begin
        if (st.div_done) begin
          cmd.ar_cap = 1'b1;
          state_next = S_FIN;
        end
      end
      S_PMUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        cmd.pchk   = 1'b1;
        state_next = st.pow_stop ? S_FIN : S_PMUL;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### rtl/decimal_accumulator_machine_step_top.sv
// Top level of the decimal accumulator machine: controller plus datapath.
//
//  channel     dir  handshake      payload
//  item_in     in   valid/ready    action, address, word
//  result_out  out  valid/ready    status, out_value, counter, accum_value
//
// One item at a time. A load item, or a step that is refused (machine stopped,
// counter out of range), goes from dispatch straight to commit. The instruction
// word is split into opcode and operand by a reciprocal multiply in two steps, so
// branch, newline, halt and decode faults commit after decode, memory operations
// after an operand read, and multiply after a product check. Divide and modulo
// wait on the bit-serial divider, and power runs a multiply and a check per step,
// at most 17 multiplies. After rst the memory is zeroed one word per cycle, with
// item_in.ready low meanwhile. A result waits in the output register while the
// next item is taken; commit stalls only if that register is still full.
module decimal_accumulator_machine_step_top #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input logic        clk,
  input logic        rst,
  dam_in_if.sink     item_in,
  dam_out_if.source  result_out
);
  import dam_pkg::*;

  dam_cmd_t  cmd;   // controller to datapath
  dam_stat_t st;    // datapath to controller

  dam_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  dam_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cmd        (cmd),
    .st         (st)
  );

  // Only one item in flight: ready drops right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("item accepted while another is in flight");

  // A commit always lands in the output register.
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_out.valid)
    else $error("commit did not present a result");

  // Never commit over a result that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> st.out_free)
    else $error("result register overwritten");

  // No item taken during the memory clearing pass.
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_we |-> !item_in.ready)
    else $error("input ready during memory clear");

endmodule

### tb/sv/tb_decimal_accumulator_machine_step_top.sv
// Testbench for the decimal accumulator machine: program loader, step checker and scoreboard.
import dam_pkg::*;

typedef struct {
  stat_t                    st;
  logic signed [WORD_W-1:0] outv;
  logic [ADDR_W-1:0]        cnt;
  logic signed [WORD_W-1:0] accv;
} step_result_t;

class step_scoreboard;
  int           mem [MEM_WORDS_DEF];
  int           acc;
  int           pc;
  run_t         run;
  step_result_t pending_q [$];
  int           errors;
  int           n_checked;
  int           n_steps;
  int           n_loads;

  function new();
    foreach (mem[i]) mem[i] = 0;
    acc = 0;
    pc = 0;
    run = RUN_GO;
  endfunction

  static function bit out_of_range(longint v);
    return v > VAL_LIMIT || v < -VAL_LIMIT;
  endfunction

  // Integer power; 0 means the result left the value range or zero was raised to a negative power.
  static function bit raise(longint b, longint e, output longint res);
    res = 1;
    if (e < 0) begin
      if (b == 0) return 0;
      if (b == 1) res = 1;
      else if (b == -1) res = ((-e) & 1) ? -1 : 1;
      else res = 0;
      return 1;
    end
    if (e == 0) return 1;
    if (b == 0 || b == 1) begin
      res = b;
      return 1;
    end
    if (b == -1) begin
      res = (e & 1) ? -1 : 1;
      return 1;
    end
    while (e > 0) begin
      res = res * b;
      if (out_of_range(res)) return 0;
      e--;
    end
    return 1;
  endfunction

  // One instruction step; state is written back only when commit is set.
  function step_result_t run_step(int w, bit commit);
    step_result_t rs;
    longint a, m, r;
    int     p, ir, opc, opd, em;
    run_t   nrun;
    bit     mem_op, wr;
    rs.st = ST_EXEC;
    a = acc; p = pc; nrun = run; em = 0; wr = 0; m = 0; r = 0; opc = 0; opd = 0;
    if (run != RUN_GO) rs.st = ST_IDLE;
    else if (pc >= MEM_WORDS_DEF) rs.st = ST_BADOP;
    else begin
      ir = mem[pc];
      opc = ir / DEC_BASE;
      opd = ir % DEC_BASE;
      mem_op = (opc == OP_READ || opc == OP_WRITE || opc == OP_LOAD ||
                (opc >= OP_ADD && opc <= OP_POW));
      if (opd < 0 || (mem_op && opd >= MEM_WORDS_DEF)) rs.st = ST_BADOP;
      else begin
        if (mem_op) m = mem[opd];
        case (opc)
          OP_READ:  wr = 1;
          OP_WRITE: begin
            rs.st = ST_OUT;
            em = int'(m);
          end
          OP_NL:    rs.st = ST_NL;
          OP_LOAD:  a = m;
          OP_ADD:   r = a + m;
          OP_SUB:   r = a - m;
          OP_MUL:   r = a * m;
          OP_DIV:   if (m == 0) rs.st = ST_DIV0; else r = a / m;
          OP_MOD:   if (m == 0) rs.st = ST_DIV0; else r = a % m;
          OP_POW:   if (!raise(a, m, r)) rs.st = ST_OVF;
          OP_BR, OP_BRN, OP_BRZ, OP_HALT: ;
          default:  rs.st = ST_BADCODE;
        endcase
        if (rs.st == ST_EXEC && opc >= OP_ADD && opc <= OP_POW) begin
          if (out_of_range(r)) rs.st = ST_OVF;
          else a = r;
        end
      end
      if (rs.st inside {ST_EXEC, ST_OUT, ST_NL}) begin
        if (opc == OP_HALT) begin
          rs.st = ST_HALT;
          nrun = RUN_HALTED;
        end else if (opc == OP_BR || (opc == OP_BRN && a < 0) ||
                     (opc == OP_BRZ && a == 0)) begin
          p = opd;
        end else begin
          p = (p + 1) & 1023;
        end
      end else begin
        nrun = RUN_FAULT;
        wr = 0;
      end
    end
    rs.outv = em[WORD_W-1:0];
    rs.cnt  = p[ADDR_W-1:0];
    rs.accv = a[WORD_W-1:0];
    if (commit) begin
      acc = int'(a);
      pc = p;
      run = nrun;
      if (wr) mem[opd] = w;
    end
    return rs;
  endfunction

  // Outcome of stepping cand placed at the counter, without changing state.
  function step_result_t try_instr(int cand);
    step_result_t rs;
    int           saved;
    saved = mem[pc];
    mem[pc] = cand;
    rs = run_step(0, 0);
    mem[pc] = saved;
    return rs;
  endfunction

  function void note_input(bit action, int address, int w);
    step_result_t rs;
    if (action == 1'b0) begin
      n_loads++;
      if (address < MEM_WORDS_DEF) mem[address] = w;
      rs.st = ST_LOADED;
      rs.outv = '0;
      rs.cnt = pc[ADDR_W-1:0];
      rs.accv = acc[WORD_W-1:0];
    end else begin
      n_steps++;
      rs = run_step(w, 1);
    end
    pending_q.push_back(rs);
  endfunction

  function void check_result(logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] outv,
                             logic [ADDR_W-1:0] cnt, logic signed [WORD_W-1:0] accv);
    step_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result status=%0d", $time, st);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      errors++;
    end
    if (outv !== e.outv) begin
      $display("%0t: out_value expected %0d actual %0d", $time, e.outv, outv);
      errors++;
    end
    if (cnt !== e.cnt) begin
      $display("%0t: counter expected %0d actual %0d", $time, e.cnt, cnt);
      errors++;
    end
    if (accv !== e.accv) begin
      $display("%0t: accum_value expected %0d actual %0d", $time, e.accv, accv);
      errors++;
    end
  endfunction
endclass

module tb_decimal_accumulator_machine_step_top;
  localparam int CYCLE_LIMIT = 800000;
  localparam int N_ITEMS     = 1850;

  logic clk = 1'b0;
  logic rst;

  dam_in_if  item_in ();
  dam_out_if result_out ();

  decimal_accumulator_machine_step_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out)
  );

  step_scoreboard sb = new();

  int n_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;
  int cycles;

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("decimal_accumulator_machine_step_top test failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready)
      sb.check_result(result_out.status, result_out.out_value,
                      result_out.counter, result_out.accum_value);
  end

  // Offer one item; it is noted as accepted at the edge where ready is seen.
  task automatic send_item(bit action, int address, int w);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
    item_in.valid   <= 1'b1;
    item_in.action  <= action;
    item_in.address <= address[ADDR_W-1:0];
    item_in.word    <= w[WORD_W-1:0];
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    sb.note_input(action, address, w);
    n_sent++;
  endtask

  // Put an instruction at the counter and execute it.
  task automatic run_instr(int instr, int w);
    send_item(1'b0, sb.pc, instr);
    send_item(1'b1, $urandom_range(1023), w);
  endtask

  function automatic int rand_word();
    int v;
    case ($urandom_range(4))
      0: v = int'($urandom_range(40)) - 20;
      1: v = int'($urandom_range(1998)) - 999;
      2: v = int'($urandom_range(199998)) - VAL_LIMIT;
      3: begin
        v = int'($urandom_range(262143));
        if (v >= 131072) v -= 262144;
      end
      default: v = int'($urandom_range(10));
    endcase
    return v;
  endfunction

  // A random instruction that keeps the machine running, when one is found.
  task automatic safe_step();
    int           ops [14] = '{OP_READ, OP_WRITE, OP_NL, OP_LOAD, OP_ADD, OP_SUB, OP_DIV,
                               OP_MUL, OP_MOD, OP_POW, OP_BR, OP_BRN, OP_BRZ, OP_HALT};
    int           opd, cand, tries;
    step_result_t rs;
    bit           ok;
    opd = $urandom_range(999);
    if ($urandom_range(99) < 60) send_item(1'b0, opd, rand_word());
    // sometimes re-run whatever the counter points at
    if ($urandom_range(99) < 15) begin
      rs = sb.try_instr(sb.mem[sb.pc]);
      if (rs.st inside {ST_EXEC, ST_OUT, ST_NL} && rs.cnt < MEM_WORDS_DEF) begin
        send_item(1'b1, $urandom_range(1023), rand_word());
        return;
      end
    end
    ok = 0;
    cand = 0;
    for (tries = 0; tries < 12 && !ok; tries++) begin
      cand = ops[$urandom_range(13)] * DEC_BASE + opd;
      rs = sb.try_instr(cand);
      ok = rs.st inside {ST_EXEC, ST_OUT, ST_NL} && rs.cnt < MEM_WORDS_DEF;
      opd = $urandom_range(999);
    end
    // jump back to the start: safe even at the last word
    if (!ok) cand = OP_BR * DEC_BASE;
    run_instr(cand, rand_word());
  endtask

  initial begin
    int kind;
    cycles = 0;
    n_sent = 0;
    hold_cycles = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 36;
    rst = 1'b1;
    item_in.valid   <= 1'b0;
    item_in.action  <= 1'b0;
    item_in.address <= '0;
    item_in.word    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: data words, ignored loads past memory, then every operation but halt
    send_item(1'b0, 900, VAL_LIMIT);
    send_item(1'b0, 901, -VAL_LIMIT);
    send_item(1'b0, 1023, -131072);
    send_item(1'b0, 1000, 131071);
    run_instr(OP_READ * DEC_BASE + 902, 7);
    run_instr(OP_WRITE * DEC_BASE + 901, 0);
    run_instr(OP_NL * DEC_BASE, 0);
    run_instr(OP_LOAD * DEC_BASE + 902, 0);
    run_instr(OP_ADD * DEC_BASE + 902, 0);
    run_instr(OP_MUL * DEC_BASE + 902, 0);
    run_instr(OP_DIV * DEC_BASE + 902, 0);
    run_instr(OP_MOD * DEC_BASE + 902, 0);
    run_instr(OP_BRZ * DEC_BASE + 50, 0);
    run_instr(OP_SUB * DEC_BASE + 902, 0);
    send_item(1'b0, 905, 3);
    run_instr(OP_POW * DEC_BASE + 905, 0);      // odd power of a negative base
    run_instr(OP_BRN * DEC_BASE + 100, 0);
    send_item(1'b0, 903, -3);
    run_instr(OP_POW * DEC_BASE + 903, 0);      // negative exponent, big base
    run_instr(OP_POW * DEC_BASE + 904, 0);      // zero to the zero
    run_instr(OP_BR * DEC_BASE + 600, 0);
    run_instr(OP_LOAD * DEC_BASE + 900, 0);

    // random programs; no-idle stretch, a long result hold-off, a full drain
    while (n_sent < N_ITEMS) begin
      tx_idle_pct = (n_sent > 400 && n_sent < 700) ? 0 : 36;
      rx_idle_pct = tx_idle_pct;
      if (n_sent >= 900 && n_sent < 903 && hold_cycles == 0) hold_cycles = 400;
      if (n_sent >= 1300 && n_sent < 1303 && sb.pending_q.size() != 0) begin
        item_in.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 15)
        send_item(1'b0, $urandom_range(1023), rand_word());
      else
        safe_step();
    end

    // the machine stops only once per reset: pick one way to stop it
    kind = $urandom_range(6);
    case (kind)
      0: run_instr(OP_HALT * DEC_BASE, 0);
      1: begin
        send_item(1'b0, 500, VAL_LIMIT);
        run_instr(OP_LOAD * DEC_BASE + 500, 0);
        run_instr(OP_ADD * DEC_BASE + 500, 0);
      end
      2: begin
        send_item(1'b0, 501, 0);
        run_instr(OP_MOD * DEC_BASE + 501, 0);
      end
      3: run_instr(-1, 0);                          // negative operand
      4: run_instr(36000, 0);                       // float opcode is unknown
      5: begin                                      // counter runs off the end
        run_instr(OP_BR * DEC_BASE + 999, 0);
        run_instr(OP_NL * DEC_BASE, 0);
        send_item(1'b1, 0, 0);
      end
      default: run_instr(-20005, 0);
    endcase
    repeat (4) begin
      send_item(1'b1, $urandom_range(1023), rand_word());
      send_item(1'b0, $urandom_range(1023), rand_word());
    end
    item_in.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items (%0d loads, %0d steps), checked %0d results.",
             n_sent, sb.n_loads, sb.n_steps, sb.n_checked);
    $display("Final counter %0d, accumulator %0d, stop kind %0d.", sb.pc, sb.acc, kind);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("decimal_accumulator_machine_step_top test passed");
    end else begin
      $display("decimal_accumulator_machine_step_top test failed");
    end
    $finish;
  end
endmodule
